@@ sv/bufu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffered UART FIFO pair package
// Sizes, request codes and item types shared by the FIFO pair.
// ----------------------------------------------------------------------------
package bufu_pkg;

  localparam int RX_DEPTH = 1024;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);

  // request codes
  localparam logic [1:0] REQ_HOST_WR = 2'd0;
  localparam logic [1:0] REQ_HOST_RD = 2'd1;
  localparam logic [1:0] REQ_SERVICE = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] host_byte;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       tx_ready;
  } in_item_t;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       tx_irq_enabled;
    logic       rx_dropped;
    logic       tx_dropped;
  } out_item_t;

  // result flags held while the memory read is in flight
  typedef struct packed {
    logic rd_valid;
    logic ln_valid;
    logic irq;
    logic rx_drop;
    logic tx_drop;
  } pend_t;

endpackage

@@ sv/buffered_uart_fifo_pair.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffered UART FIFO pair
// Receive and transmit ring FIFOs in front of a serial port, one item per
// host access or port service event, one result item per input item.
// ----------------------------------------------------------------------------
// Each FIFO is a ring of RX_DEPTH / TX_DEPTH byte slots in a synchronous
// memory and holds at most depth-1 bytes. Host writes push to the transmit
// FIFO and set the transmit interrupt enable; a write to a full transmit FIFO
// is dropped and flagged. Host reads pop the receive FIFO (read_valid low when
// empty). A service event may push a received byte (dropped and flagged when
// full) and, with tx_ready and the enable set, pop one byte to the line or
// clear the enable when nothing is left. Timing: an item is decided and its
// memory access issued in the cycle it is accepted, and the byte lands in the
// memory read register at the accepting edge; the result is loaded into the
// output register from there when the output slot is free or being emptied,
// and the result item is offered from the output register. While results are
// taken as they appear, one item is accepted every cycle; a stalled output
// holds at most one finished result plus one item waiting on its read data.
// ----------------------------------------------------------------------------
module buffered_uart_fifo_pair (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bufu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bufu_pkg::out_item_t out_data
);

  // ring pointers
  logic [bufu_pkg::RX_AW-1:0] rx_head_r, rx_head_nxt;
  logic [bufu_pkg::RX_AW-1:0] rx_tail_r, rx_tail_nxt;
  logic [bufu_pkg::TX_AW-1:0] tx_head_r, tx_head_nxt;
  logic [bufu_pkg::TX_AW-1:0] tx_tail_r, tx_tail_nxt;
  logic                       irq_r, irq_nxt;

  // byte stores
  logic [7:0] rx_mem [bufu_pkg::RX_DEPTH];
  logic [7:0] tx_mem [bufu_pkg::TX_DEPTH];
  logic [7:0] rx_rdata_r;
  logic [7:0] tx_rdata_r;

  // item waiting on its read data
  logic            pend_valid_r, pend_valid_nxt;
  bufu_pkg::pend_t pend_r, pend_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  bufu_pkg::out_item_t out_item_r, out_item_nxt;

  logic in_fire;
  logic load;
  logic rx_we, rx_re, tx_we, tx_re;
  logic rx_full, rx_empty, tx_full, tx_empty;

  assign rx_full  = (rx_head_r + bufu_pkg::RX_AW'(1)) == rx_tail_r;
  assign tx_full  = (tx_head_r + bufu_pkg::TX_AW'(1)) == tx_tail_r;
  assign rx_empty = rx_head_r == rx_tail_r;
  assign tx_empty = tx_head_r == tx_tail_r;

  // Move the pending item into the output slot when the slot is free or
  // being emptied this cycle; take a new item whenever the pending stage frees.
  assign load     = pend_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !pend_valid_r || load;
  assign in_fire  = in_valid && in_ready;

  // Decide the item against the current pointers and issue memory accesses.
  always_comb begin
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    irq_nxt     = irq_r;
    pend_nxt    = '0;
    if (in_fire) begin
      unique case (in_data.req_type)
        bufu_pkg::REQ_HOST_WR: begin
          if (tx_full) begin
            pend_nxt.tx_drop = 1'b1;
          end else begin
            tx_we       = 1'b1;
            tx_head_nxt = tx_head_r + bufu_pkg::TX_AW'(1);
          end
          irq_nxt = 1'b1;
        end
        bufu_pkg::REQ_HOST_RD: begin
          if (!rx_empty) begin
            rx_re             = 1'b1;
            pend_nxt.rd_valid = 1'b1;
            rx_tail_nxt       = rx_tail_r + bufu_pkg::RX_AW'(1);
          end
        end
        bufu_pkg::REQ_SERVICE: begin
          // receive side first, then transmit side
          if (in_data.rx_ready) begin
            if (rx_full) begin
              pend_nxt.rx_drop = 1'b1;
            end else begin
              rx_we       = 1'b1;
              rx_head_nxt = rx_head_r + bufu_pkg::RX_AW'(1);
            end
          end
          if (in_data.tx_ready && irq_r) begin
            if (tx_empty) begin
              irq_nxt = 1'b0;
            end else begin
              tx_re             = 1'b1;
              pend_nxt.ln_valid = 1'b1;
              tx_tail_nxt       = tx_tail_r + bufu_pkg::TX_AW'(1);
            end
          end
        end
        default: begin
          // unused code: no state change
        end
      endcase
    end
    pend_nxt.irq = irq_nxt;
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_head_r] <= in_data.rx_byte;
    end
    if (rx_re) begin
      rx_rdata_r <= rx_mem[rx_tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_head_r] <= in_data.host_byte;
    end
    if (tx_re) begin
      tx_rdata_r <= tx_mem[tx_tail_r];
    end
  end

  // Pending stage and output register next values.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      pend_valid_nxt              = 1'b0;
      out_valid_nxt               = 1'b1;
      out_item_nxt.read_valid     = pend_r.rd_valid;
      out_item_nxt.read_byte      = pend_r.rd_valid ? rx_rdata_r : 8'd0;
      out_item_nxt.line_valid     = pend_r.ln_valid;
      out_item_nxt.line_byte      = pend_r.ln_valid ? tx_rdata_r : 8'd0;
      out_item_nxt.tx_irq_enabled = pend_r.irq;
      out_item_nxt.rx_dropped     = pend_r.rx_drop;
      out_item_nxt.tx_dropped     = pend_r.tx_drop;
    end
    if (in_fire) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r    <= '0;
      rx_tail_r    <= '0;
      tx_head_r    <= '0;
      tx_tail_r    <= '0;
      irq_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rx_head_r    <= rx_head_nxt;
      rx_tail_r    <= rx_tail_nxt;
      tx_head_r    <= tx_head_nxt;
      tx_tail_r    <= tx_tail_nxt;
      irq_r        <= irq_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= pend_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef SYNTH
  // a push never leaves the receive ring looking empty
  a_rx_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    rx_we |=> rx_head_r != rx_tail_r)
    else $error("receive push left FIFO empty");

  // a transmit pop never moves the transmit write pointer
  a_tx_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    tx_re |=> $stable(tx_head_r))
    else $error("transmit pop moved head");

  // a byte goes to the line only while the enable is set
  a_line_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.line_valid |-> out_item_r.tx_irq_enabled)
    else $error("line byte sent with enable clear");

  // a pending item that cannot move to the output is not lost
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && !load |=> pend_valid_r)
    else $error("pending item lost");
`endif

endmodule
